FILE: hw/rtl/multichannel_biquad_df2_macros.svh
// Assertion macros used by the biquad controller, mbq_ctrl.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef MULTICHANNEL_BIQUAD_DF2_MACROS_SVH
`define MULTICHANNEL_BIQUAD_DF2_MACROS_SVH

// Same-cycle implication.
`define MBQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("biquad assertion failed");

// Next-cycle implication.
`define MBQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("biquad assertion failed");

`endif

FILE: hw/rtl/mbq_pkg.sv
// Package for the multichannel biquad: widths, codes, register and command types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mbq_pkg;

  localparam int CHANNELS       = 8;
  localparam int CH_IDX_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CHAN_W         = 3;
  localparam int SAMPLE_BITS    = 24;
  localparam int COEF_W         = 32;
  localparam int COEF_FRAC_BITS = 28;
  localparam int STATE_W        = 40;
  localparam int STATE_SHIFT    = 8;
  localparam int ACTIVE_W       = 4;
  localparam int REG_IDX_W      = 3;
  localparam int REG_DATA_W     = 32;

  localparam int SPLIT_W = 16;
  localparam int HI_W    = STATE_W - SPLIT_W;
  localparam int OPND_W  = HI_W + 1;
  localparam int PROD_W  = COEF_W + OPND_W;
  localparam int PART_W  = COEF_W + STATE_W;
  localparam int TERM_W  = PART_W - COEF_FRAC_BITS;
  localparam int ACC_W   = TERM_W + 4;

  localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(1) << COEF_FRAC_BITS;
  localparam logic [ACTIVE_W-1:0]      ACTIVE_RESET = ACTIVE_W'(8);

  localparam logic CMD_CLEAR = 1'b1;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_COEF_B0 = 3'd0,
    REG_COEF_B1 = 3'd1,
    REG_COEF_B2 = 3'd2,
    REG_COEF_A1 = 3'd3,
    REG_COEF_A2 = 3'd4,
    REG_ACTIVE  = 3'd5
  } reg_idx_e;

  typedef enum logic [2:0] {
    COEF_B0 = 3'd0,
    COEF_B1 = 3'd1,
    COEF_B2 = 3'd2,
    COEF_A1 = 3'd3,
    COEF_A2 = 3'd4
  } coef_sel_e;

  typedef enum logic [1:0] {
    OPND_DLY1 = 2'd0,
    OPND_DLY2 = 2'd1,
    OPND_NEW  = 2'd2
  } opnd_sel_e;

  typedef enum logic {
    ACC_DST_W = 1'b0,
    ACC_DST_Y = 1'b1
  } acc_dst_e;

  typedef struct packed {
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
    logic [ACTIVE_W-1:0]      active;
  } cfg_t;

  typedef struct packed {
    logic      load;
    logic      clear;
    logic      rd_en;
    logic      acc_init;
    logic      mul_en;
    logic      mul_hi;
    logic      mul_neg;
    coef_sel_e coef;
    opnd_sel_e opnd;
    acc_dst_e  dst;
    logic      w_en;
    logic      wr_en;
    logic      out_load;
    logic      out_pass;
  } cmd_t;

  typedef struct packed {
    logic is_clear;
    logic is_pass;
  } sts_t;

endpackage

`default_nettype wire

FILE: hw/rtl/mbq_if.sv
// Handshake channel interfaces: sample input, result output, register write.
// Depends on mbq_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface mbq_in_if import mbq_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic                          command;
  logic [CHAN_W-1:0]             channel;
  logic signed [SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, command, channel, sample_in, input ready);
  modport sink   (input valid, command, channel, sample_in, output ready);
endinterface

interface mbq_out_if import mbq_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic [CHAN_W-1:0]             out_channel;
  logic signed [SAMPLE_BITS-1:0] sample_out;

  modport source (output valid, out_channel, sample_out, input ready);
  modport sink   (input valid, out_channel, sample_out, output ready);
endinterface

interface mbq_cfg_if import mbq_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [REG_IDX_W-1:0]  index;
  logic [REG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/mbq_regs.sv
// Configuration register file: coefficients and active channel count.
// Depends on mbq_pkg and mbq_cfg_if.
`timescale 1ns / 1ps
`default_nettype none

module mbq_regs import mbq_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  mbq_cfg_if.sink    cfg_i,
  output cfg_t       cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (reg_idx_e'(cfg_i.index))
        REG_COEF_B0: cfg_d.b0     = $signed(cfg_i.data[COEF_W-1:0]);
        REG_COEF_B1: cfg_d.b1     = $signed(cfg_i.data[COEF_W-1:0]);
        REG_COEF_B2: cfg_d.b2     = $signed(cfg_i.data[COEF_W-1:0]);
        REG_COEF_A1: cfg_d.a1     = $signed(cfg_i.data[COEF_W-1:0]);
        REG_COEF_A2: cfg_d.a2     = $signed(cfg_i.data[COEF_W-1:0]);
        REG_ACTIVE:  cfg_d.active = cfg_i.data[ACTIVE_W-1:0];
        default:     cfg_d        = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.b0     <= COEF_ONE;
      cfg_q.b1     <= '0;
      cfg_q.b2     <= '0;
      cfg_q.a1     <= '0;
      cfg_q.a2     <= '0;
      cfg_q.active <= ACTIVE_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/mbq_datapath.sv
// Datapath: delay-state memories, shared multiplier, rounding accumulators, output register.
// Depends on mbq_pkg; driven by mbq_ctrl commands.
`timescale 1ns / 1ps
`default_nettype none

module mbq_datapath import mbq_pkg::*; (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           command_i,
  input  wire [CHAN_W-1:0]              channel_i,
  input  wire signed [SAMPLE_BITS-1:0]  sample_i,
  input  cfg_t                          cfg_i,
  input  cmd_t                          cmd_i,
  output sts_t                          sts_o,
  output logic [CHAN_W-1:0]             out_channel_o,
  output logic signed [SAMPLE_BITS-1:0] sample_out_o
);

  localparam int CMP_W = 8;
  localparam logic signed [PART_W-1:0] PART_ROUND = PART_W'(1) << (COEF_FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0]  Y_ROUND    = ACC_W'(1) << (STATE_SHIFT - 1);
  localparam logic signed [ACC_W-1:0]  W_MAX = ACC_W'({1'b0, {(STATE_W - 1){1'b1}}});
  localparam logic signed [ACC_W-1:0]  W_MIN = ~W_MAX;
  localparam logic signed [ACC_W-1:0]  Y_MAX = ACC_W'({1'b0, {(SAMPLE_BITS - 1){1'b1}}});
  localparam logic signed [ACC_W-1:0]  Y_MIN = ~Y_MAX;

  logic                          cmd_q;
  logic [CHAN_W-1:0]             ch_q;
  logic signed [SAMPLE_BITS-1:0] x_q;
  logic [CH_IDX_W-1:0]           idx;

  logic signed [STATE_W-1:0] dly1_mem [CHANNELS];
  logic signed [STATE_W-1:0] dly2_mem [CHANNELS];
  logic [CHANNELS-1:0]       valid_q;
  logic                      rd_vld_q;
  logic signed [STATE_W-1:0] w1_raw_q, w2_raw_q;
  logic signed [STATE_W-1:0] w1_val, w2_val;
  logic signed [STATE_W-1:0] w_q, w_sat;

  logic signed [COEF_W-1:0]  coef_op;
  logic signed [STATE_W-1:0] w_op;
  logic signed [OPND_W-1:0]  mul_op;
  logic signed [PROD_W-1:0]  prod_d, prod_q;
  logic                      p_vld_q, p_hi_q, p_neg_q;
  acc_dst_e                  p_dst_q;

  logic signed [PART_W-1:0]  part_q, part_add, part_base;
  logic                      a_vld_q, a_neg_q;
  acc_dst_e                  a_dst_q;
  logic signed [ACC_W-1:0]   term, term_s;
  logic signed [ACC_W-1:0]   accw_q, accy_q, y_rnd;
  logic signed [SAMPLE_BITS-1:0] y_sat;

  // Item capture and channel decode
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q <= command_i;
      ch_q  <= channel_i;
      x_q   <= sample_i;
    end
  end

  assign idx = CH_IDX_W'(ch_q);
  assign sts_o.is_clear = (cmd_q == CMD_CLEAR);
  assign sts_o.is_pass  = !((CMP_W'(ch_q) < CMP_W'(cfg_i.active)) &&
                            (CMP_W'(ch_q) < CMP_W'(CHANNELS)));

  // Delay state
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      dly1_mem[idx] <= w_q;
      dly2_mem[idx] <= w1_val;
    end
    if (cmd_i.rd_en) begin
      w1_raw_q <= dly1_mem[idx];
      w2_raw_q <= dly2_mem[idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        valid_q <= '0;
      end else if (cmd_i.wr_en) begin
        valid_q[idx] <= 1'b1;
      end
      if (cmd_i.rd_en) begin
        rd_vld_q <= valid_q[idx];
      end
    end
  end

  assign w1_val = rd_vld_q ? w1_raw_q : '0;
  assign w2_val = rd_vld_q ? w2_raw_q : '0;

  // Shared multiplier, one half of the state word per cycle
  always_comb begin
    case (cmd_i.coef)
      COEF_B0: coef_op = cfg_i.b0;
      COEF_B1: coef_op = cfg_i.b1;
      COEF_B2: coef_op = cfg_i.b2;
      COEF_A1: coef_op = cfg_i.a1;
      COEF_A2: coef_op = cfg_i.a2;
      default: coef_op = '0;
    endcase
    case (cmd_i.opnd)
      OPND_DLY1: w_op = w1_val;
      OPND_DLY2: w_op = w2_val;
      OPND_NEW:  w_op = w_q;
      default:   w_op = '0;
    endcase
    if (cmd_i.mul_hi) begin
      mul_op = OPND_W'($signed(w_op[STATE_W-1:SPLIT_W]));
    end else begin
      mul_op = $signed({{(OPND_W - SPLIT_W){1'b0}}, w_op[SPLIT_W-1:0]});
    end
  end

  assign prod_d = coef_op * mul_op;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  // Exact product assembly and per-term rounding
  assign part_add  = p_hi_q ? (PART_W'(prod_q) <<< SPLIT_W) : PART_W'(prod_q);
  assign part_base = p_hi_q ? part_q : PART_ROUND;

  always_ff @(posedge clk_i) begin
    if (p_vld_q) begin
      part_q <= part_base + part_add;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
      p_hi_q  <= 1'b0;
      p_neg_q <= 1'b0;
      p_dst_q <= ACC_DST_W;
      a_vld_q <= 1'b0;
      a_neg_q <= 1'b0;
      a_dst_q <= ACC_DST_W;
    end else begin
      p_vld_q <= cmd_i.mul_en;
      p_hi_q  <= cmd_i.mul_hi;
      p_neg_q <= cmd_i.mul_neg;
      p_dst_q <= cmd_i.dst;
      a_vld_q <= p_vld_q && p_hi_q;
      a_neg_q <= p_neg_q;
      a_dst_q <= p_dst_q;
    end
  end

  assign term   = ACC_W'($signed(part_q[PART_W-1:COEF_FRAC_BITS]));
  assign term_s = a_neg_q ? -term : term;

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_init) begin
      accw_q <= ACC_W'(x_q) <<< STATE_SHIFT;
      accy_q <= '0;
    end else if (a_vld_q) begin
      if (a_dst_q == ACC_DST_W) begin
        accw_q <= accw_q + term_s;
      end else begin
        accy_q <= accy_q + term_s;
      end
    end
  end

  // Saturate the new state word
  assign w_sat = (accw_q > W_MAX) ? STATE_W'(W_MAX) :
                 (accw_q < W_MIN) ? STATE_W'(W_MIN) : accw_q[STATE_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.w_en) begin
      w_q <= w_sat;
    end
  end

  // Round and saturate the result
  assign y_rnd = (accy_q + Y_ROUND) >>> STATE_SHIFT;
  assign y_sat = (y_rnd > Y_MAX) ? SAMPLE_BITS'(Y_MAX) :
                 (y_rnd < Y_MIN) ? SAMPLE_BITS'(Y_MIN) : y_rnd[SAMPLE_BITS-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_channel_o <= ch_q;
      sample_out_o  <= cmd_i.out_pass ? x_q : y_sat;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/mbq_ctrl.sv
// Controller: item handshake, multiply schedule, output register valid.
// Depends on mbq_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "multichannel_biquad_df2_macros.svh"

module mbq_ctrl import mbq_pkg::*; (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  wire  out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(11);
  localparam logic [STEP_W-1:0] STEP_SAT  = STEP_W'(6);
  localparam logic [STEP_W-1:0] STEP_WB   = STEP_W'(7);
  localparam logic [STEP_W-1:0] STEP_MULS = STEP_W'(10);

  localparam logic [STEP_W-2:0] PAIR_A1 = 3'd0;
  localparam logic [STEP_W-2:0] PAIR_A2 = 3'd1;
  localparam logic [STEP_W-2:0] PAIR_B1 = 3'd2;
  localparam logic [STEP_W-2:0] PAIR_B2 = 3'd3;
  localparam logic [STEP_W-2:0] PAIR_B0 = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CHECK = 4'b0010,
    ST_CALC  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              out_valid_q, out_valid_d;
  cmd_t              cmd_d;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd_d;

  always_comb begin
    cmd_d   = '0;
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_d.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts_i.is_clear) begin
          cmd_d.clear = 1'b1;
          state_d     = ST_IDLE;
        end else if (sts_i.is_pass) begin
          state_d = ST_DONE;
        end else begin
          cmd_d.rd_en    = 1'b1;
          cmd_d.acc_init = 1'b1;
          step_d         = '0;
          state_d        = ST_CALC;
        end
      end
      ST_CALC: begin
        step_d       = step_q + STEP_W'(1);
        cmd_d.mul_en = (step_q < STEP_MULS);
        cmd_d.mul_hi = step_q[0];
        case (step_q[STEP_W-1:1])
          PAIR_A1: begin
            cmd_d.coef    = COEF_A1;
            cmd_d.opnd    = OPND_DLY1;
            cmd_d.dst     = ACC_DST_W;
            cmd_d.mul_neg = 1'b1;
          end
          PAIR_A2: begin
            cmd_d.coef    = COEF_A2;
            cmd_d.opnd    = OPND_DLY2;
            cmd_d.dst     = ACC_DST_W;
            cmd_d.mul_neg = 1'b1;
          end
          PAIR_B1: begin
            cmd_d.coef = COEF_B1;
            cmd_d.opnd = OPND_DLY1;
            cmd_d.dst  = ACC_DST_Y;
          end
          PAIR_B2: begin
            cmd_d.coef = COEF_B2;
            cmd_d.opnd = OPND_DLY2;
            cmd_d.dst  = ACC_DST_Y;
          end
          PAIR_B0: begin
            cmd_d.coef = COEF_B0;
            cmd_d.opnd = OPND_NEW;
            cmd_d.dst  = ACC_DST_Y;
          end
          default: begin
            cmd_d.mul_en = 1'b0;
          end
        endcase
        cmd_d.w_en  = (step_q == STEP_SAT);
        cmd_d.wr_en = (step_q == STEP_WB);
        if (step_q == STEP_LAST) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_d.out_load = 1'b1;
          cmd_d.out_pass = sts_i.is_pass;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = (out_valid_q && !out_ready_i) || cmd_d.out_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  `MBQ_ASSERT_IMP(a_out_load_free, cmd_o.out_load, !out_valid_q || out_ready_i)
  `MBQ_ASSERT_NXT(a_accept_check, in_valid_i && in_ready_o, state_q == ST_CHECK)
  `MBQ_ASSERT_NXT(a_calc_to_done, (state_q == ST_CALC) && (step_q == STEP_LAST), state_q == ST_DONE)

endmodule

`default_nettype wire

FILE: hw/rtl/multichannel_biquad_df2.sv
// Top level of the multichannel direct form II biquad.
// Depends on mbq_pkg, mbq_if, mbq_regs, mbq_datapath and mbq_ctrl.
//
//   channel  dir  payload                        accepted when
//   in_i     in   command, channel, sample_in    valid && ready
//   out_o    out  out_channel, sample_out        valid && ready
//   cfg_i    in   index, data                    valid && ready (ready always high)
//
// A filtered item makes ten passes through the one shared 32 x 25 multiplier (two halves
// of the state word per term, five terms), then the accumulators drain. A passthrough item
// skips the multiplier and a clear goes back to idle from the check. New items enter only in idle.
// Reset is asynchronous: coefficients return to defaults, delay state reads zero through
// per-channel valid bits. A one-entry output register holds a result while the sink
// stalls; the next item is accepted meanwhile and waits at its end until the register frees.
`timescale 1ns / 1ps
`default_nettype none

module multichannel_biquad_df2 import mbq_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  mbq_in_if.sink     in_i,
  mbq_out_if.source  out_o,
  mbq_cfg_if.sink    cfg_i
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;
  logic out_valid;

  mbq_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  mbq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mbq_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .command_i     (in_i.command),
    .channel_i     (in_i.channel),
    .sample_i      (in_i.sample_in),
    .cfg_i         (cfg),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_channel_o (out_o.out_channel),
    .sample_out_o  (out_o.sample_out)
  );

  assign out_o.valid = out_valid;

endmodule

`default_nettype wire

FILE: test/mbq_checker.sv
// Scoreboard for the multichannel biquad: watches the sample, result and register channels,
// predicts every filtered or passed item and compares it field by field with the block's output.
// Depends on mbq_pkg and mbq_if.
`timescale 1ns / 1ps

module mbq_checker import mbq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  mbq_in_if    in_mon,
  mbq_out_if   out_mon,
  mbq_cfg_if   cfg_mon,
  output int   fail_cnt_o,
  output int   pending_o,
  output int   checked_o
);

  typedef struct packed {
    logic [CHAN_W-1:0]             chan;
    logic signed [SAMPLE_BITS-1:0] smp;
  } biquad_out_t;

  localparam longint W_MAX = (longint'(1) <<< (STATE_W - 1)) - 1;
  localparam longint W_MIN = -W_MAX - 1;
  localparam longint Y_MAX = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint Y_MIN = -Y_MAX - 1;
  localparam longint Y_HALF = longint'(1) <<< (STATE_SHIFT - 1);

  logic signed [COEF_W-1:0]  b0, b1, b2, a1, a2;
  logic [ACTIVE_W-1:0]       n_active;
  logic signed [STATE_W-1:0] w1_mem [CHANNELS];
  logic signed [STATE_W-1:0] w2_mem [CHANNELS];
  biquad_out_t               filtered_q [$];
  int                        fails;
  int                        checked;

  // Exact product, rounded half up to the delay format.
  function automatic longint coef_mul(input logic signed [COEF_W-1:0] c,
                                      input logic signed [STATE_W-1:0] w);
    logic signed [COEF_W+STATE_W-1:0] p;
    p = c * w + (1 <<< (COEF_FRAC_BITS - 1));
    return longint'(p >>> COEF_FRAC_BITS);
  endfunction

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  task automatic predict_item(input logic cmd, input logic [CHAN_W-1:0] ch,
                              input logic signed [SAMPLE_BITS-1:0] x);
    longint      lim;
    longint      w;
    longint      y;
    biquad_out_t res;
    lim = (n_active > CHANNELS) ? CHANNELS : n_active;
    res.chan = ch;
    if (cmd == CMD_CLEAR) begin
      foreach (w1_mem[i]) begin
        w1_mem[i] = '0;
        w2_mem[i] = '0;
      end
    end else if (ch >= lim) begin
      res.smp = x;
      filtered_q.push_back(res);
    end else begin
      w = (longint'(x) <<< STATE_SHIFT) - coef_mul(a1, w1_mem[ch]) - coef_mul(a2, w2_mem[ch]);
      w = clamp(w, W_MIN, W_MAX);
      y = coef_mul(b0, STATE_W'(w)) + coef_mul(b1, w1_mem[ch]) + coef_mul(b2, w2_mem[ch]);
      y = clamp((y + Y_HALF) >>> STATE_SHIFT, Y_MIN, Y_MAX);
      w2_mem[ch] = w1_mem[ch];
      w1_mem[ch] = STATE_W'(w);
      res.smp = SAMPLE_BITS'(y);
      filtered_q.push_back(res);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    biquad_out_t want;
    if (!rst_ni) begin
      b0 = COEF_ONE;
      b1 = '0;
      b2 = '0;
      a1 = '0;
      a2 = '0;
      n_active = ACTIVE_RESET;
      foreach (w1_mem[i]) begin
        w1_mem[i] = '0;
        w2_mem[i] = '0;
      end
      filtered_q.delete();
      fails = 0;
      checked = 0;
      fail_cnt_o <= 0;
      pending_o <= 0;
      checked_o <= 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_COEF_B0: b0 = cfg_mon.data;
          REG_COEF_B1: b1 = cfg_mon.data;
          REG_COEF_B2: b2 = cfg_mon.data;
          REG_COEF_A1: a1 = cfg_mon.data;
          REG_COEF_A2: a2 = cfg_mon.data;
          REG_ACTIVE:  n_active = cfg_mon.data[ACTIVE_W-1:0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        if (filtered_q.size() == 0) begin
          $error("result with nothing expected: out_channel %0d, sample_out %0d",
                 out_mon.out_channel, out_mon.sample_out);
          fails++;
        end else begin
          want = filtered_q.pop_front();
          checked++;
          if (out_mon.out_channel !== want.chan) begin
            $error("out_channel mismatch: expected %0d, got %0d", want.chan, out_mon.out_channel);
            fails++;
          end
          if (out_mon.sample_out !== want.smp) begin
            $error("sample_out mismatch: expected %0d, got %0d", want.smp, out_mon.sample_out);
            fails++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        predict_item(in_mon.command, in_mon.channel, in_mon.sample_in);
      fail_cnt_o <= fails;
      pending_o <= filtered_q.size();
      checked_o <= checked;
    end
  end

endmodule

FILE: test/tb.sv
// Top of the biquad testbench: clock, reset, register setup and sample stimulus with idling.
// Depends on mbq_pkg, mbq_if, mbq_checker and the multichannel_biquad_df2 RTL.
`timescale 1ns / 1ps

module tb;
  import mbq_pkg::*;

  typedef enum int {CF_STABLE, CF_RANDOM, CF_HIGH, CF_LOW, CF_TINY} coef_mix_e;

  localparam int     LIMIT    = 400000;
  localparam int     SETTLE   = 40;
  localparam longint ONE      = longint'(COEF_ONE);
  localparam logic [COEF_W-1:0] C_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic [COEF_W-1:0] C_MIN = {1'b1, {(COEF_W-1){1'b0}}};
  localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  int   cycles = 0;
  int   send_idle = 0;
  int   stall_pct = 0;
  int   n_items = 0;
  int   n_clears = 0;
  int   n_settings = 0;
  int   fail_cnt;
  int   pending;
  int   checked;

  mbq_in_if  in_if ();
  mbq_out_if out_if ();
  mbq_cfg_if cfg_if ();

  multichannel_biquad_df2 u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  mbq_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_mon     (in_if),
    .out_mon    (out_if),
    .cfg_mon    (cfg_if),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending),
    .checked_o  (checked)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic put_item(input logic cmd, input logic [CHAN_W-1:0] ch,
                          input logic signed [SAMPLE_BITS-1:0] x);
    while ($urandom_range(99) < send_idle) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.command   <= cmd;
    in_if.channel   <= ch;
    in_if.sample_in <= x;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    n_items++;
    if (cmd == CMD_CLEAR) n_clears++;
  endtask

  // Hold off until every expected item has come back, then let the pipeline settle.
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [REG_DATA_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
  endtask

  task automatic program_coefs(input logic [COEF_W-1:0] b0, input logic [COEF_W-1:0] b1,
                               input logic [COEF_W-1:0] b2, input logic [COEF_W-1:0] a1,
                               input logic [COEF_W-1:0] a2, input logic [ACTIVE_W-1:0] act);
    write_reg(REG_COEF_B0, b0);
    write_reg(REG_COEF_B1, b1);
    write_reg(REG_COEF_B2, b2);
    write_reg(REG_COEF_A1, a1);
    write_reg(REG_COEF_A2, a2);
    write_reg(REG_ACTIVE, REG_DATA_W'(act));
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
    n_settings++;
  endtask

  task automatic program_filter(input coef_mix_e mix, input logic [ACTIVE_W-1:0] act);
    longint a2v;
    longint lim;
    longint a1v;
    case (mix)
      CF_STABLE: begin
        a2v = $urandom_range(0, 32'(ONE * 95 / 100));
        lim = (ONE + a2v) * 9 / 10;
        a1v = longint'($urandom_range(0, 32'(2 * lim))) - lim;
        program_coefs(32'(longint'($urandom_range(0, 32'(ONE))) - ONE / 2),
                      32'(longint'($urandom_range(0, 32'(ONE))) - ONE / 2),
                      32'(longint'($urandom_range(0, 32'(ONE))) - ONE / 2),
                      32'(a1v), 32'(a2v), act);
      end
      CF_RANDOM: program_coefs($urandom, $urandom, $urandom, $urandom, $urandom, act);
      CF_HIGH:   program_coefs(C_MAX, C_MAX, C_MAX, C_MIN, C_MAX, act);
      CF_LOW:    program_coefs(C_MIN, C_MIN, C_MIN, C_MAX, C_MIN, act);
      default:   program_coefs($urandom_range(1, 255), '1, 32'd1,
                               32'(longint'($urandom_range(0, 512)) - 256), '0, act);
    endcase
  endtask

  task automatic send_random(input int n);
    logic                          cmd;
    logic [CHAN_W-1:0]             ch;
    logic signed [SAMPLE_BITS-1:0] x;
    repeat (n) begin
      cmd = ($urandom_range(99) < 3) ? CMD_CLEAR : ~CMD_CLEAR;
      ch  = CHAN_W'($urandom_range(CHANNELS - 1));
      case ($urandom_range(9))
        0:       x = $urandom_range(1) ? S_MAX : S_MIN;
        1, 2:    x = SAMPLE_BITS'(int'($urandom_range(0, 512)) - 256);
        default: x = SAMPLE_BITS'($urandom);
      endcase
      put_item(cmd, ch, x);
    end
  endtask

  task automatic set_idle(input int mode);
    case (mode % 4)
      0: begin send_idle = 0;  stall_pct = 0;  end
      1: begin send_idle = 50; stall_pct = 0;  end
      2: begin send_idle = 0;  stall_pct = 50; end
      default: begin send_idle = 30; stall_pct = 30; end
    endcase
  endtask

  initial begin : stimulus
    in_if.valid     <= 1'b0;
    in_if.command   <= ~CMD_CLEAR;
    in_if.channel   <= '0;
    in_if.sample_in <= '0;
    cfg_if.valid    <= 1'b0;
    cfg_if.index    <= REG_COEF_B0;
    cfg_if.data     <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset coefficients give unity gain.
    put_item(~CMD_CLEAR, 3'd0, '0);
    put_item(~CMD_CLEAR, 3'd1, S_MAX);
    put_item(~CMD_CLEAR, 3'd2, S_MIN);
    put_item(~CMD_CLEAR, 3'd3, '1);
    put_item(~CMD_CLEAR, 3'd7, 24'sd1);
    put_item(CMD_CLEAR, 3'd5, SAMPLE_BITS'($urandom));
    drain();

    // Extreme coefficients, active count above the channel count: saturate w and y.
    program_coefs(C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, 4'd15);
    put_item(~CMD_CLEAR, 3'd0, S_MAX);
    put_item(~CMD_CLEAR, 3'd0, S_MIN);
    put_item(~CMD_CLEAR, 3'd0, S_MAX);
    put_item(~CMD_CLEAR, 3'd1, S_MIN);
    put_item(~CMD_CLEAR, 3'd1, S_MIN);
    put_item(~CMD_CLEAR, 3'd0, '0);
    put_item(CMD_CLEAR, 3'd0, '0);
    put_item(~CMD_CLEAR, 3'd0, S_MAX);
    drain();

    // No active channel: everything passes through.
    program_coefs(C_MIN, '0, '0, '0, '0, 4'd0);
    put_item(~CMD_CLEAR, 3'd0, S_MAX);
    put_item(~CMD_CLEAR, 3'd7, S_MIN);
    drain();

    // Three active channels, a stable resonant section.
    program_coefs(32'(ONE / 2), 32'(ONE), 32'(ONE / 2), 32'(-(ONE * 3 / 2)),
                  32'(ONE * 5 / 8), 4'd3);
    put_item(~CMD_CLEAR, 3'd2, S_MAX);
    put_item(~CMD_CLEAR, 3'd3, S_MAX);
    put_item(~CMD_CLEAR, 3'd2, '0);
    put_item(~CMD_CLEAR, 3'd4, S_MIN);
    put_item(~CMD_CLEAR, 3'd2, S_MIN);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      set_idle(ph);
      case (ph)
        0: program_filter(CF_STABLE, 4'd8);
        1: program_filter(CF_STABLE, ACTIVE_W'($urandom_range(1, 7)));
        2: program_filter(CF_RANDOM, 4'd15);
        3: program_filter(CF_HIGH, 4'd8);
        4: program_filter(CF_STABLE, 4'd0);
        5: program_filter(CF_LOW, ACTIVE_W'($urandom_range(9, 15)));
        6: program_filter(CF_STABLE, 4'd8);
        default: program_filter(CF_TINY, 4'd8);
      endcase
      send_random(120);
      // Hold the sender until the block has emptied once.
      if (ph == 3) drain();
      send_random(124);
      drain();
    end

    $display("Sent %0d items (%0d clears) under %0d register settings and four idle patterns.",
             n_items, n_clears, n_settings);
    $display("Compared %0d results against the predicted filter output.", checked);
    if (fail_cnt == 0 && pending == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/mbq_pkg.sv
hw/rtl/mbq_if.sv
hw/rtl/mbq_regs.sv
hw/rtl/mbq_datapath.sv
hw/rtl/mbq_ctrl.sv
hw/rtl/multichannel_biquad_df2.sv
test/mbq_checker.sv
test/tb.sv
